FILE: hw/rtl/dmaq_pkg.sv
`default_nettype none

package dmaq_pkg;

	// Queue sizes.
	localparam int RING_DEPTH = 128;
	localparam int PRIO_DEPTH = 8;

	// Pointer and counter widths follow from the queue sizes.
	localparam int RING_PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int PRIO_IDX_W = (PRIO_DEPTH > 1) ? $clog2(PRIO_DEPTH) : 1;
	localparam int PRIO_CNT_W = $clog2(PRIO_DEPTH + 1);

	// Source bus boundary that a transfer may not cross (128 KiB).
	localparam logic [17:0] BANK_SIZE = 18'h20000;
	localparam logic [16:0] BANK_MASK = 17'h1FFFF;

	// Command kinds.
	typedef enum logic [1:0] {
		KIND_TRANSFER = 2'd0,
		KIND_SPRITE   = 2'd1,
		KIND_FILL     = 2'd2,
		KIND_COPY     = 2'd3
	} kind_t;

	// Item modes.
	typedef enum logic {
		MODE_PUSH = 1'b0,
		MODE_POP  = 1'b1
	} mode_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PUSH_HEAD,
		ST_POP
	} state_t;

	// Input item.
	typedef struct packed {
		logic        mode;
		logic [1:0]  kind;
		logic [1:0]  target;
		logic [15:0] dest_addr;
		logic [23:0] source;
		logic [15:0] length;
		logic [7:0]  step;
	} cmd_in_t;

	// Result item.
	typedef struct packed {
		logic        empty_res;
		logic [1:0]  out_kind;
		logic [1:0]  out_target;
		logic [15:0] out_dest;
		logic [22:0] out_source;
		logic [15:0] out_length;
		logic [7:0]  out_step;
		logic        queues_drained;
	} cmd_out_t;

	// One normalized queue entry.
	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  target;
		logic [15:0] dest;
		logic [22:0] src;
		logic [15:0] len;
		logic [7:0]  step;
	} qentry_t;

	// Result of the boundary split of one push.
	typedef struct packed {
		logic    split;
		qentry_t tail;
		qentry_t head;
	} split_t;

	// Ring entry, held in two memories.
	typedef struct packed {
		logic [15:0] dest;
		logic [22:0] src;
	} ring_addr_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  target;
		logic [15:0] len;
		logic [7:0]  step;
	} ring_info_t;

	// Priority entry; its kind is always a sprite transfer.
	typedef struct packed {
		logic [1:0]  target;
		logic [15:0] dest;
		logic [22:0] src;
		logic [15:0] len;
		logic [7:0]  step;
	} prio_entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dmaq_ram.sv
`default_nettype none

// Generic memory with one write port and one registered read port.
module dmaq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AddrW-1:0] waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AddrW-1:0] raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/dmaq_split.sv
`default_nettype none

// Normalizes a pushed command and splits a transfer that would cross a
// 128 KiB source boundary into a tail part and a shortened head part.
module dmaq_split (
	input  wire dmaq_pkg::cmd_in_t cmd,
	output dmaq_pkg::split_t       parts
);

	logic        is_xfer;
	logic [17:0] limit;
	logic [16:0] half;
	logic [24:0] src_sum;

	// Bytes left below the boundary and the words that fit in them.
	always_comb begin
		is_xfer = (cmd.kind == dmaq_pkg::KIND_TRANSFER) || (cmd.kind == dmaq_pkg::KIND_SPRITE);
		limit   = dmaq_pkg::BANK_SIZE - {1'b0, cmd.source[16:0] & dmaq_pkg::BANK_MASK};
		half    = limit[17:1];
		src_sum = {1'b0, cmd.source} + {7'b0, limit};
	end

	// Build both entries.
	always_comb begin
		parts.split = is_xfer && ({1'b0, cmd.length} > half);

		parts.tail.kind   = cmd.kind;
		parts.tail.target = cmd.target;
		parts.tail.dest   = cmd.dest_addr + limit[15:0];
		parts.tail.src    = src_sum[23:1];
		parts.tail.len    = cmd.length - half[15:0];
		parts.tail.step   = cmd.step;

		parts.head.kind   = cmd.kind;
		parts.head.target = cmd.target;
		parts.head.dest   = cmd.dest_addr;
		parts.head.src    = is_xfer ? cmd.source[23:1] : {7'b0, cmd.source[15:0]};
		parts.head.len    = parts.split ? half[15:0] : cmd.length;
		parts.head.step   = cmd.step;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/dma_command_queue_with_split_core.sv
`default_nettype none

// Video DMA command queue. An item is taken when start is high and busy is
// low. A push queues sprite transfers in a small priority queue and every
// other command in the main ring; a transfer that crosses a 128 KiB source
// boundary becomes a tail entry followed by a shortened head entry. A push
// that finds its queue full is dropped without notice. A push that makes one
// entry leaves busy low; a push that splits holds busy in ST_PUSH_HEAD while
// it writes the head entry, since each entry is one write into the
// single-write-port queue memories. A pop holds busy in ST_POP while the
// queue memories read, and its result is registered with done high as the
// block leaves ST_POP, in the first cycle that busy is low again.
// The result is shown for exactly one cycle and cannot be held off, so the
// receiver must take it when done is high. A push gives no result.
module dma_command_queue_with_split_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire dmaq_pkg::cmd_in_t  cmd,
	output logic                    busy,
	output logic                    done,
	output dmaq_pkg::cmd_out_t      result
);

	localparam int RPW = dmaq_pkg::RING_PTR_W;
	localparam int PCW = dmaq_pkg::PRIO_CNT_W;
	localparam int PIW = dmaq_pkg::PRIO_IDX_W;

	dmaq_pkg::state_t state_q, state_d;

	logic [RPW-1:0] ring_wp_q, ring_rp_q;
	logic [PCW-1:0] prio_cnt_q, prio_rp_q;

	dmaq_pkg::split_t  parts;
	dmaq_pkg::qentry_t head_q;
	dmaq_pkg::qentry_t put_e;
	logic              put_valid;

	logic           accept, accept_push, accept_pop;
	logic           prio_found, ring_found;
	logic [RPW-1:0] ring_wp_next, ring_rp_next;
	logic [PCW-1:0] prio_rp_inc, prio_rp_new, prio_cnt_new, prio_rp_upd;
	logic           prio_we, ring_we;

	logic sel_prio_s1, found_s1, drained_s1;

	dmaq_pkg::cmd_out_t result_d;

	dmaq_pkg::ring_addr_t  ring_addr_wr, ring_addr_rd;
	dmaq_pkg::ring_info_t  ring_info_wr, ring_info_rd;
	dmaq_pkg::prio_entry_t prio_wr, prio_rd;
	logic [$bits(dmaq_pkg::ring_addr_t)-1:0]  ring_addr_rdata;
	logic [$bits(dmaq_pkg::ring_info_t)-1:0]  ring_info_rdata;
	logic [$bits(dmaq_pkg::prio_entry_t)-1:0] prio_rdata;

	function automatic logic [RPW-1:0] ring_next(input logic [RPW-1:0] p);
		return (p == RPW'(dmaq_pkg::RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	dmaq_split u_split (
		.cmd   (cmd),
		.parts (parts)
	);

	assign accept      = start && !busy;
	assign accept_push = accept && (cmd.mode == dmaq_pkg::MODE_PUSH);
	assign accept_pop  = accept && (cmd.mode == dmaq_pkg::MODE_POP);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dmaq_pkg::ST_IDLE: begin
				if (accept_pop) begin
					state_d = dmaq_pkg::ST_POP;
				end else if (accept_push && parts.split) begin
					state_d = dmaq_pkg::ST_PUSH_HEAD;
				end
			end
			dmaq_pkg::ST_PUSH_HEAD: state_d = dmaq_pkg::ST_IDLE;
			dmaq_pkg::ST_POP:       state_d = dmaq_pkg::ST_IDLE;
			default:                state_d = dmaq_pkg::ST_IDLE;
		endcase
	end

	// State outputs: busy and the entry written this cycle.
	always_comb begin
		busy      = 1'b1;
		put_valid = 1'b0;
		put_e     = parts.head;
		unique case (state_q)
			dmaq_pkg::ST_IDLE: begin
				busy      = 1'b0;
				put_valid = accept_push;
				put_e     = parts.split ? parts.tail : parts.head;
			end
			dmaq_pkg::ST_PUSH_HEAD: begin
				put_valid = 1'b1;
				put_e     = head_q;
			end
			dmaq_pkg::ST_POP: begin
				put_valid = 1'b0;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// Route the entry to its queue; a full queue drops it.
	always_comb begin
		ring_wp_next = ring_next(ring_wp_q);
		prio_we = 1'b0;
		ring_we = 1'b0;
		if (put_valid) begin
			if (put_e.kind == dmaq_pkg::KIND_SPRITE) begin
				prio_we = prio_cnt_q < PCW'(dmaq_pkg::PRIO_DEPTH);
			end else begin
				ring_we = ring_wp_next != ring_rp_q;
			end
		end
		ring_addr_wr = '{dest: put_e.dest, src: put_e.src};
		ring_info_wr = '{kind: put_e.kind, target: put_e.target,
			len: put_e.len, step: put_e.step};
		prio_wr = '{target: put_e.target, dest: put_e.dest, src: put_e.src,
			len: put_e.len, step: put_e.step};
	end

	// Pop: choose the queue and advance its read pointer.
	always_comb begin
		prio_found   = prio_rp_q < prio_cnt_q;
		ring_found   = !prio_found && (ring_rp_q != ring_wp_q);
		prio_rp_inc  = prio_rp_q + PCW'(1);
		prio_rp_upd  = prio_found ? prio_rp_inc : prio_rp_q;
		ring_rp_next = ring_found ? ring_next(ring_rp_q) : ring_rp_q;
		if (prio_rp_upd >= prio_cnt_q) begin
			prio_rp_new  = '0;
			prio_cnt_new = '0;
		end else begin
			prio_rp_new  = prio_rp_upd;
			prio_cnt_new = prio_cnt_q;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dmaq_pkg::ST_IDLE;
			ring_wp_q  <= '0;
			ring_rp_q  <= '0;
			prio_cnt_q <= '0;
			prio_rp_q  <= '0;
			done       <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= state_q == dmaq_pkg::ST_POP;
			if (ring_we) begin
				ring_wp_q <= ring_wp_next;
			end
			if (prio_we) begin
				prio_cnt_q <= prio_cnt_q + PCW'(1);
			end
			if (accept_pop) begin
				ring_rp_q  <= ring_rp_next;
				prio_rp_q  <= prio_rp_new;
				prio_cnt_q <= prio_cnt_new;
			end
		end
	end

	// Head entry of a split push, and pop bookkeeping that travels with the memory read.
	always_ff @(posedge clk) begin
		if (accept_push && parts.split) begin
			head_q <= parts.head;
		end
		if (accept_pop) begin
			sel_prio_s1 <= prio_found;
			found_s1    <= prio_found || ring_found;
			drained_s1  <= (prio_cnt_new == '0) && (ring_rp_next == ring_wp_q);
		end
	end

	assign ring_addr_rd = dmaq_pkg::ring_addr_t'(ring_addr_rdata);
	assign ring_info_rd = dmaq_pkg::ring_info_t'(ring_info_rdata);
	assign prio_rd      = dmaq_pkg::prio_entry_t'(prio_rdata);

	// Result value built from the read data.
	always_comb begin
		result_d = '0;
		result_d.empty_res      = !found_s1;
		result_d.queues_drained = drained_s1;
		if (found_s1 && sel_prio_s1) begin
			result_d.out_kind   = dmaq_pkg::KIND_SPRITE;
			result_d.out_target = prio_rd.target;
			result_d.out_dest   = prio_rd.dest;
			result_d.out_source = prio_rd.src;
			result_d.out_length = prio_rd.len;
			result_d.out_step   = prio_rd.step;
		end else if (found_s1) begin
			result_d.out_kind   = ring_info_rd.kind;
			result_d.out_target = ring_info_rd.target;
			result_d.out_dest   = ring_addr_rd.dest;
			result_d.out_source = ring_addr_rd.src;
			result_d.out_length = ring_info_rd.len;
			result_d.out_step   = ring_info_rd.step;
		end
	end

	// Result register, loaded as the read data arrives.
	always_ff @(posedge clk) begin
		if (state_q == dmaq_pkg::ST_POP) begin
			result <= result_d;
		end
	end

	// Queue memories.
	dmaq_ram #(
		.WIDTH ($bits(dmaq_pkg::ring_addr_t)),
		.DEPTH (dmaq_pkg::RING_DEPTH)
	) u_ring_addr (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_wp_q),
		.wdata (ring_addr_wr),
		.re    (accept_pop),
		.raddr (ring_rp_q),
		.rdata (ring_addr_rdata)
	);

	dmaq_ram #(
		.WIDTH ($bits(dmaq_pkg::ring_info_t)),
		.DEPTH (dmaq_pkg::RING_DEPTH)
	) u_ring_info (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_wp_q),
		.wdata (ring_info_wr),
		.re    (accept_pop),
		.raddr (ring_rp_q),
		.rdata (ring_info_rdata)
	);

	dmaq_ram #(
		.WIDTH ($bits(dmaq_pkg::prio_entry_t)),
		.DEPTH (dmaq_pkg::PRIO_DEPTH)
	) u_prio (
		.clk   (clk),
		.we    (prio_we),
		.waddr (prio_cnt_q[PIW-1:0]),
		.wdata (prio_wr),
		.re    (accept_pop),
		.raddr (prio_rp_q[PIW-1:0]),
		.rdata (prio_rdata)
	);

endmodule

`default_nettype wire
